/* hw/rtl/motor_current_power_limiter_top_defines.svh */
// assertion helpers for the power limiter
`ifndef MOTOR_CURRENT_POWER_LIMITER_TOP_DEFINES_SVH
`define MOTOR_CURRENT_POWER_LIMITER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MCPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcpl assertion failed");

// condition must never hold
`define MCPL_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mcpl assertion failed");

`endif

/* hw/rtl/mcpl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mcpl_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int CUR_W      = 16;
    localparam int MAG_W      = CUR_W + 1;
    localparam int LIMIT_W    = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'd131070;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0]  WARN_BUFFER_RST   = 10'd100;
    localparam logic [9:0]  MIN_BUFFER_RST    = 10'd5;
    localparam logic [15:0] BUFFER_CUR_RST    = 16'd16000;
    localparam logic [15:0] POWER_CUR_RST     = 16'd20000;

    // full power limit in centiwatts fits 23 bits
    localparam int FULL_W     = 23;
    localparam int LDIV_NUM_W = 40;
    localparam int LDIV_DEN_W = FULL_W;
    localparam int LDIV_QUO_W = 26;
    localparam int SDIV_NUM_W = 2 * MAG_W;
    localparam int SDIV_QUO_W = MAG_W;

    // pipeline depth from request to result
    localparam int LATENCY = 3 + LDIV_QUO_W + 3 + SDIV_QUO_W;

    typedef enum logic [1:0] {
        CFG_WARN_BUFFER  = 2'd0,
        CFG_MIN_BUFFER   = 2'd1,
        CFG_BUFFER_LIMIT = 2'd2,
        CFG_POWER_LIMIT  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_LOW   = 2'd0,
        MODE_FULL  = 2'd1,
        MODE_TAPER = 2'd2,
        MODE_BASE  = 2'd3
    } limit_mode_t;

    typedef struct packed {
        logic [9:0]  warn_buffer;
        logic [9:0]  min_buffer;
        logic [15:0] buffer_current_limit;
        logic [15:0] extra_current_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        power_cw;
        logic [15:0]        buffer_energy;
        logic [15:0]        power_limit_w;
        logic signed [15:0] current_a;
        logic signed [15:0] current_b;
        logic signed [15:0] current_c;
        logic signed [15:0] current_d;
    } request_t;

    typedef struct packed {
        logic signed [15:0] scaled_a;
        logic signed [15:0] scaled_b;
        logic signed [15:0] scaled_c;
        logic signed [15:0] scaled_d;
        logic [16:0]        total_limit;
        logic               was_limited;
    } result_t;

endpackage
`default_nettype wire

/* hw/rtl/mcpl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcpl_div #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 23,
    parameter int QUO_W  = 26,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic              valid_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  work_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    logic              valid_in [QUO_W];
    logic [DEN_W-1:0]  rem_in   [QUO_W];
    logic [QUO_W-1:0]  work_in  [QUO_W];
    logic [DEN_W-1:0]  den_in   [QUO_W];
    logic [SIDE_W-1:0] side_in_s [QUO_W];

    logic [DEN_W-1:0]  rem_next  [QUO_W];
    logic [QUO_W-1:0]  work_next [QUO_W];

    // stage inputs: first from the ports, others from the stage before
    always_comb
    begin
        valid_in[0]  = in_valid;
        rem_in[0]    = DEN_W'(num >> QUO_W);
        work_in[0]   = num[QUO_W-1:0];
        den_in[0]    = den;
        side_in_s[0] = side_in;
        for (int k = 1; k < QUO_W; k++)
        begin
            valid_in[k]  = valid_reg[k-1];
            rem_in[k]    = rem_reg[k-1];
            work_in[k]   = work_reg[k-1];
            den_in[k]    = den_reg[k-1];
            side_in_s[k] = side_reg[k-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++)
        begin : g_stage
            logic [DEN_W:0] trial;
            logic           ge;

            // one restoring step: shift in a numerator bit, try subtract
            always_comb
            begin
                trial        = {rem_in[g], work_in[g][QUO_W-1]};
                ge           = trial >= {1'b0, den_in[g]};
                rem_next[g]  = ge ? DEN_W'(trial - {1'b0, den_in[g]}) : trial[DEN_W-1:0];
                work_next[g] = {work_in[g][QUO_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else
                begin
                    valid_reg[g] <= valid_in[g];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next[g];
                work_reg[g] <= work_next[g];
                den_reg[g]  <= den_in[g];
                side_reg[g] <= side_in_s[g];
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = work_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

/* hw/rtl/mcpl_limit.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcpl_limit #(
    parameter int SIDE_W = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [15:0]                   power_cw,
    input  wire logic [15:0]                   buffer_energy,
    input  wire logic [15:0]                   power_limit_w,
    input  wire mcpl_pkg::cfg_t                cfg,
    input  wire logic [SIDE_W-1:0]             side_in,
    output logic                               out_valid,
    output logic [mcpl_pkg::LIMIT_W-1:0]       limit,
    output logic [SIDE_W-1:0]                  side_out
);

    localparam int DSIDE_W = SIDE_W + 2;

    // stage a: buffer floor, low buffer test, full limit in centiwatts
    logic                          a_valid_reg;
    logic [15:0]                   a_power_reg;
    logic [mcpl_pkg::FULL_W-1:0]   a_full_reg;
    logic                          a_low_reg;
    logic [25:0]                   a_num_lo_reg;
    logic [SIDE_W-1:0]             a_side_reg;

    logic [9:0]                    e_floor;
    logic                          a_low_next;
    logic [mcpl_pkg::FULL_W-1:0]   a_full_next;
    logic [25:0]                   a_num_lo_next;

    always_comb
    begin
        e_floor       = (buffer_energy[9:0] > cfg.min_buffer) ? buffer_energy[9:0]
                                                              : cfg.min_buffer;
        a_low_next    = buffer_energy < {6'd0, cfg.warn_buffer};
        a_full_next   = mcpl_pkg::FULL_W'(power_limit_w) * 23'd100;
        a_num_lo_next = 26'(cfg.buffer_current_limit) * 26'(e_floor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_power_reg  <= power_cw;
        a_full_reg   <= a_full_next;
        a_low_reg    <= a_low_next;
        a_num_lo_reg <= a_num_lo_next;
        a_side_reg   <= side_in;
    end

    // stage b: pick the branch and form the division operands
    logic                               b_valid_reg;
    mcpl_pkg::limit_mode_t              b_mode_reg;
    logic [mcpl_pkg::LDIV_NUM_W-1:0]    b_num_reg;
    logic [mcpl_pkg::LDIV_DEN_W-1:0]    b_den_reg;
    logic [SIDE_W-1:0]                  b_side_reg;

    mcpl_pkg::limit_mode_t              b_mode_next;
    logic [mcpl_pkg::LDIV_NUM_W-1:0]    b_num_next;
    logic [mcpl_pkg::LDIV_DEN_W-1:0]    b_den_next;
    logic [mcpl_pkg::FULL_W-1:0]        diff;
    logic [mcpl_pkg::LDIV_NUM_W-1:0]    num_taper;
    logic                               at_half;
    logic                               below_full;

    always_comb
    begin
        at_half    = mcpl_pkg::FULL_W'({a_power_reg, 1'b0}) <= a_full_reg;
        below_full = mcpl_pkg::FULL_W'(a_power_reg) < a_full_reg;
        diff       = a_full_reg - mcpl_pkg::FULL_W'(a_power_reg);
        num_taper  = mcpl_pkg::LDIV_NUM_W'({cfg.extra_current_limit, 1'b0})
                     * mcpl_pkg::LDIV_NUM_W'(diff);
        priority if (a_low_reg)
        begin
            b_mode_next = mcpl_pkg::MODE_LOW;
            b_num_next  = mcpl_pkg::LDIV_NUM_W'(a_num_lo_reg);
            b_den_next  = mcpl_pkg::LDIV_DEN_W'(cfg.warn_buffer);
        end
        else if (at_half)
        begin
            b_mode_next = mcpl_pkg::MODE_FULL;
            b_num_next  = '0;
            b_den_next  = mcpl_pkg::LDIV_DEN_W'(1);
        end
        else if (below_full)
        begin
            b_mode_next = mcpl_pkg::MODE_TAPER;
            b_num_next  = num_taper;
            b_den_next  = a_full_reg;
        end
        else
        begin
            b_mode_next = mcpl_pkg::MODE_BASE;
            b_num_next  = '0;
            b_den_next  = mcpl_pkg::LDIV_DEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_mode_reg <= b_mode_next;
        b_num_reg  <= b_num_next;
        b_den_reg  <= b_den_next;
        b_side_reg <= a_side_reg;
    end

    // pipelined quotient
    logic                               d_valid;
    logic [mcpl_pkg::LDIV_QUO_W-1:0]    d_quo;
    logic [DSIDE_W-1:0]                 d_side;

    mcpl_div #(
        .NUM_W  (mcpl_pkg::LDIV_NUM_W),
        .DEN_W  (mcpl_pkg::LDIV_DEN_W),
        .QUO_W  (mcpl_pkg::LDIV_QUO_W),
        .SIDE_W (DSIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (b_num_reg),
        .den       (b_den_reg),
        .side_in   ({b_mode_reg, b_side_reg}),
        .out_valid (d_valid),
        .quo       (d_quo),
        .side_out  (d_side)
    );

    // stage c: add the base share where the branch calls for it, and saturate
    logic                               c_valid_reg;
    logic [mcpl_pkg::LIMIT_W-1:0]       c_limit_reg;
    logic [SIDE_W-1:0]                  c_side_reg;

    mcpl_pkg::limit_mode_t              d_mode;
    logic [26:0]                        cand;
    logic [mcpl_pkg::LIMIT_W-1:0]       c_limit_next;

    always_comb
    begin
        d_mode = mcpl_pkg::limit_mode_t'(d_side[DSIDE_W-1:SIDE_W]);
        unique case (d_mode)
            mcpl_pkg::MODE_LOW:   cand = 27'(d_quo);
            mcpl_pkg::MODE_TAPER: cand = 27'(d_quo) + 27'(cfg.buffer_current_limit);
            mcpl_pkg::MODE_FULL:  cand = 27'(cfg.buffer_current_limit)
                                         + 27'(cfg.extra_current_limit);
            default:              cand = 27'(cfg.buffer_current_limit);
        endcase
        c_limit_next = (cand > 27'(mcpl_pkg::LIMIT_MAX)) ? mcpl_pkg::LIMIT_MAX
                                                         : cand[mcpl_pkg::LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c_limit_reg <= c_limit_next;
        c_side_reg  <= d_side[SIDE_W-1:0];
    end

    assign out_valid = c_valid_reg;
    assign limit     = c_limit_reg;
    assign side_out  = c_side_reg;

endmodule
`default_nettype wire

/* hw/rtl/mcpl_scale.sv */
`timescale 1ns / 1ps
`default_nettype none
module mcpl_scale #(
    parameter int NUM_MOTORS = mcpl_pkg::NUM_MOTORS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    input  wire logic [mcpl_pkg::LIMIT_W-1:0]            limit,
    input  wire logic signed [mcpl_pkg::CUR_W-1:0]       cur [NUM_MOTORS],
    output logic                                         out_valid,
    output logic signed [mcpl_pkg::CUR_W-1:0]            scaled [NUM_MOTORS],
    output logic [mcpl_pkg::LIMIT_W-1:0]                 limit_out,
    output logic                                         limited
);

    localparam int CUR_W  = mcpl_pkg::CUR_W;
    localparam int MAG_W  = mcpl_pkg::MAG_W;
    localparam int LIM_W  = mcpl_pkg::LIMIT_W;
    localparam int TOT_W  = $clog2(NUM_MOTORS) + CUR_W;
    localparam int NUM_W  = mcpl_pkg::SDIV_NUM_W;
    localparam int QUO_W  = mcpl_pkg::SDIV_QUO_W;
    localparam int SIDE_W = CUR_W + 1;

    // stage 1: magnitudes and signs
    logic               s1_valid_reg;
    logic [MAG_W-1:0]   s1_mag_reg [NUM_MOTORS];
    logic [CUR_W-1:0]   s1_cur_reg [NUM_MOTORS];
    logic [LIM_W-1:0]   s1_limit_reg;
    logic [MAG_W-1:0]   s1_mag_next [NUM_MOTORS];

    always_comb
    begin
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            s1_mag_next[k] = cur[k][CUR_W-1] ? MAG_W'(~{cur[k][CUR_W-1], cur[k]} + 1'b1)
                                             : {1'b0, cur[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            s1_mag_reg[k] <= s1_mag_next[k];
            s1_cur_reg[k] <= cur[k];
        end
        s1_limit_reg <= limit;
    end

    // stage 2: total magnitude, over-limit test, numerators
    logic               s2_valid_reg;
    logic [TOT_W-1:0]   s2_total_reg;
    logic               s2_limited_reg;
    logic [NUM_W-1:0]   s2_prod_reg [NUM_MOTORS];
    logic [CUR_W-1:0]   s2_cur_reg  [NUM_MOTORS];
    logic [LIM_W-1:0]   s2_limit_reg;

    logic [TOT_W-1:0]   s2_total_next;
    logic               s2_limited_next;

    always_comb
    begin
        s2_total_next = '0;
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            s2_total_next = s2_total_next + TOT_W'(s1_mag_reg[k]);
        end
        s2_limited_next = s2_total_next > TOT_W'(s1_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            s2_prod_reg[k] <= NUM_W'(s1_mag_reg[k]) * NUM_W'(s1_limit_reg);
            s2_cur_reg[k]  <= s1_cur_reg[k];
        end
        s2_total_reg   <= s2_total_next;
        s2_limited_reg <= s2_limited_next;
        s2_limit_reg   <= s1_limit_reg;
    end

    // one divider per motor, shared flags ride alongside
    logic               d_valid [NUM_MOTORS];
    logic [QUO_W-1:0]   d_quo   [NUM_MOTORS];
    logic [SIDE_W-1:0]  d_side  [NUM_MOTORS];

    genvar g;
    generate
        for (g = 0; g < NUM_MOTORS; g++)
        begin : g_div
            mcpl_div #(
                .NUM_W  (NUM_W),
                .DEN_W  (TOT_W),
                .QUO_W  (QUO_W),
                .SIDE_W (SIDE_W)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (s2_valid_reg),
                .num       (s2_prod_reg[g]),
                .den       (s2_total_reg),
                .side_in   ({s2_cur_reg[g][CUR_W-1], s2_cur_reg[g]}),
                .out_valid (d_valid[g]),
                .quo       (d_quo[g]),
                .side_out  (d_side[g])
            );
        end
    endgenerate

    logic [LIM_W:0]     flag_reg [QUO_W];

    always_ff @(posedge clk)
    begin
        flag_reg[0] <= {s2_limited_reg, s2_limit_reg};
        for (int k = 1; k < QUO_W; k++)
        begin
            flag_reg[k] <= flag_reg[k-1];
        end
    end

    // final stage: restore sign or pass through
    logic               f_valid_reg;
    logic [CUR_W-1:0]   f_scaled_reg [NUM_MOTORS];
    logic [LIM_W-1:0]   f_limit_reg;
    logic               f_limited_reg;
    logic [CUR_W-1:0]   f_scaled_next [NUM_MOTORS];
    logic               d_limited;

    always_comb
    begin
        d_limited = flag_reg[QUO_W-1][LIM_W];
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            if (!d_limited)
            begin
                f_scaled_next[k] = d_side[k][CUR_W-1:0];
            end
            else if (d_side[k][CUR_W])
            begin
                f_scaled_next[k] = CUR_W'(0) - d_quo[k][CUR_W-1:0];
            end
            else
            begin
                f_scaled_next[k] = d_quo[k][CUR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= d_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            f_scaled_reg[k] <= f_scaled_next[k];
        end
        f_limit_reg   <= flag_reg[QUO_W-1][LIM_W-1:0];
        f_limited_reg <= d_limited;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            scaled[k] = $signed(f_scaled_reg[k]);
        end
    end

    assign out_valid = f_valid_reg;
    assign limit_out = f_limit_reg;
    assign limited   = f_limited_reg;

endmodule
`default_nettype wire

/* hw/rtl/motor_current_power_limiter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// motor current power limiter
// a request (power, buffer energy, power limit, four signed currents) is
// taken at a clock edge where start is high and busy is low; busy stays
// low, so a request may be issued every cycle.
// the result (four limited currents, total limit, limited flag) appears on
// result with done high for exactly one cycle, after the limit path (two
// operand stages, a 26-step pipelined divider, a saturation stage) and
// the scaling path (magnitude, sum and product stages, 17-step per-motor
// dividers, a sign stage). throughput is one request per cycle.
// configuration is written through cfg_we / cfg_index / cfg_data with no
// wait; write it only while no request is in flight.
// reset clears all pipeline valid bits and loads the default register
// values; requests in flight are dropped.
// the receiver cannot hold results off, and none is needed: every result
// is presented once, in request order.
`include "motor_current_power_limiter_top_defines.svh"
module motor_current_power_limiter_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire mcpl_pkg::request_t                 request,
    input  wire logic                               cfg_we,
    input  wire logic [mcpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcpl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                    done,
    output mcpl_pkg::result_t                       result
);

    localparam int NM     = mcpl_pkg::NUM_MOTORS;
    localparam int CUR_W  = mcpl_pkg::CUR_W;
    localparam int SIDE_W = NM * CUR_W;

    // configuration registers
    mcpl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_buffer          <= mcpl_pkg::WARN_BUFFER_RST;
            cfg_reg.min_buffer           <= mcpl_pkg::MIN_BUFFER_RST;
            cfg_reg.buffer_current_limit <= mcpl_pkg::BUFFER_CUR_RST;
            cfg_reg.extra_current_limit  <= mcpl_pkg::POWER_CUR_RST;
        end
        else if (cfg_we)
        begin
            unique case (mcpl_pkg::cfg_reg_t'(cfg_index))
                mcpl_pkg::CFG_WARN_BUFFER:  cfg_reg.warn_buffer          <= cfg_data[9:0];
                mcpl_pkg::CFG_MIN_BUFFER:   cfg_reg.min_buffer           <= cfg_data[9:0];
                mcpl_pkg::CFG_BUFFER_LIMIT: cfg_reg.buffer_current_limit <= cfg_data;
                mcpl_pkg::CFG_POWER_LIMIT:  cfg_reg.extra_current_limit  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign busy = 1'b0;

    // currents ride through the limit path
    logic [SIDE_W-1:0] cur_flat;
    logic [SIDE_W-1:0] cur_flat_d;

    assign cur_flat = {request.current_d, request.current_c,
                       request.current_b, request.current_a};

    logic                               lim_valid;
    logic [mcpl_pkg::LIMIT_W-1:0]       lim_value;

    mcpl_limit #(
        .SIDE_W (SIDE_W)
    ) u_limit (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .power_cw      (request.power_cw),
        .buffer_energy (request.buffer_energy),
        .power_limit_w (request.power_limit_w),
        .cfg           (cfg_reg),
        .side_in       (cur_flat),
        .out_valid     (lim_valid),
        .limit         (lim_value),
        .side_out      (cur_flat_d)
    );

    logic signed [CUR_W-1:0] cur_arr    [NM];
    logic signed [CUR_W-1:0] scaled_arr [NM];
    logic                    scl_valid;
    logic [mcpl_pkg::LIMIT_W-1:0] scl_limit;
    logic                    scl_limited;

    always_comb
    begin
        for (int k = 0; k < NM; k++)
        begin
            cur_arr[k] = $signed(cur_flat_d[k*CUR_W +: CUR_W]);
        end
    end

    mcpl_scale #(
        .NUM_MOTORS (NM)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lim_valid),
        .limit     (lim_value),
        .cur       (cur_arr),
        .out_valid (scl_valid),
        .scaled    (scaled_arr),
        .limit_out (scl_limit),
        .limited   (scl_limited)
    );

    // result port
    always_comb
    begin
        result.scaled_a    = scaled_arr[0];
        result.scaled_b    = scaled_arr[1];
        result.scaled_c    = scaled_arr[2];
        result.scaled_d    = scaled_arr[3];
        result.total_limit = scl_limit;
        result.was_limited = scl_limited;
    end

    assign done = scl_valid;

    `MCPL_ASSERT_IMPLY(a_req_gives_result, clk, rst_n, start && !busy, ##49 done)
    `MCPL_ASSERT_IMPLY(a_result_had_req, clk, rst_n, done, $past(start, 49))
    `MCPL_ASSERT_NEVER(a_limit_saturated, clk, rst_n, done && (result.total_limit > mcpl_pkg::LIMIT_MAX))

endmodule
`default_nettype wire

/* test/tb_motor_current_power_limiter_top.sv */
`timescale 1ns / 1ps
module tb_motor_current_power_limiter_top;

    localparam int DRAIN_CYCLES = mcpl_pkg::LATENCY + 10;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int N_DIRECTED   = 14;
    localparam int N_PHASES     = 7;
    localparam int RAND_PER_PHASE = 190;

    typedef struct {
        mcpl_pkg::request_t req;
        bit                 has_exp;
        mcpl_pkg::result_t  exp;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    mcpl_pkg::request_t request;
    logic     cfg_we;
    logic [mcpl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mcpl_pkg::CFG_DATA_W-1:0] cfg_data;
    logic     done;
    mcpl_pkg::result_t  result;

    mcpl_pkg::cfg_t     cfg_shadow;
    mcpl_pkg::result_t  pending_results [$];
    dir_row_t dir_table [N_DIRECTED];
    int       err_count;
    int       sent_count;
    int       seen_count;
    int       limited_count;
    int       cycle_count;
    bit       no_idle;

    motor_current_power_limiter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // total current limit and scaled currents for one request
    function automatic mcpl_pkg::result_t predict_limit(mcpl_pkg::cfg_t c,
                                                        mcpl_pkg::request_t r);
        longint unsigned lim;
        longint unsigned e;
        longint unsigned full_cw;
        longint unsigned total;
        longint unsigned mag [mcpl_pkg::NUM_MOTORS];
        longint signed   cur [mcpl_pkg::NUM_MOTORS];
        logic signed [15:0] outv [mcpl_pkg::NUM_MOTORS];
        mcpl_pkg::result_t res;
        cur[0] = r.current_a;
        cur[1] = r.current_b;
        cur[2] = r.current_c;
        cur[3] = r.current_d;
        if (r.buffer_energy < c.warn_buffer)
        begin
            e = (r.buffer_energy > c.min_buffer) ? r.buffer_energy : c.min_buffer;
            lim = (longint'(c.buffer_current_limit) * e) / c.warn_buffer;
        end
        else
        begin
            full_cw = longint'(r.power_limit_w) * 100;
            if (2 * longint'(r.power_cw) <= full_cw)
                lim = longint'(c.buffer_current_limit) + c.extra_current_limit;
            else if (longint'(r.power_cw) < full_cw)
                lim = longint'(c.buffer_current_limit) +
                      (longint'(c.extra_current_limit) * 2 *
                       (full_cw - r.power_cw)) / full_cw;
            else
                lim = c.buffer_current_limit;
        end
        if (lim > mcpl_pkg::LIMIT_MAX)
            lim = mcpl_pkg::LIMIT_MAX;
        total = 0;
        for (int i = 0; i < mcpl_pkg::NUM_MOTORS; i++)
        begin
            mag[i] = (cur[i] < 0) ? -cur[i] : cur[i];
            total += mag[i];
        end
        for (int i = 0; i < mcpl_pkg::NUM_MOTORS; i++)
        begin
            if (total > lim)
            begin
                mag[i] = (mag[i] * lim) / total;
                outv[i] = (cur[i] < 0) ? -16'(mag[i]) : 16'(mag[i]);
            end
            else
                outv[i] = 16'(cur[i]);
        end
        res.scaled_a    = outv[0];
        res.scaled_b    = outv[1];
        res.scaled_c    = outv[2];
        res.scaled_d    = outv[3];
        res.total_limit = lim[16:0];
        res.was_limited = (total > lim);
        return res;
    endfunction

    function automatic mcpl_pkg::request_t mk_req(int p, int b, int l, int a, int bb,
                                                  int cc, int d);
        mcpl_pkg::request_t r;
        r.power_cw      = 16'(p);
        r.buffer_energy = 16'(b);
        r.power_limit_w = 16'(l);
        r.current_a     = 16'(a);
        r.current_b     = 16'(bb);
        r.current_c     = 16'(cc);
        r.current_d     = 16'(d);
        return r;
    endfunction

    function automatic mcpl_pkg::result_t mk_res(int a, int b, int c, int d, int lim, bit lm);
        mcpl_pkg::result_t r;
        r.scaled_a    = 16'(a);
        r.scaled_b    = 16'(b);
        r.scaled_c    = 16'(c);
        r.scaled_d    = 16'(d);
        r.total_limit = 17'(lim);
        r.was_limited = lm;
        return r;
    endfunction

    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (no_idle || sel < 60)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int rand_current();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return $signed(16'($urandom));
        else if (sel == 1)
            return $urandom_range(0, 4000) - 2000;
        else
            return $urandom_range(0, 30000) - 15000;
    endfunction

    // random request biased across the limit branches
    function automatic mcpl_pkg::request_t rand_request();
        int branch;
        int b;
        int l;
        int p;
        branch = $urandom_range(0, 4);
        l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 655);
        case (branch)
            0: b = $urandom_range(0, cfg_shadow.warn_buffer);
            1: b = $urandom_range(0, 1100);
            default: b = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
            0: p = $urandom_range(0, 65535);
            1: p = (l * 50 > 65535) ? 65535 : l * 50;
            2: p = (l * 100 > 65535) ? $urandom_range(0, 65535)
                                      : $urandom_range(l * 50, l * 100);
            default: p = (l * 100 > 65535) ? 65535 : l * 100 + $urandom_range(0, 5);
        endcase
        if (p > 65535)
            p = 65535;
        return mk_req(p, b, l, rand_current(), rand_current(), rand_current(),
                      rand_current());
    endfunction

    // issue one request and log its expected result on acceptance
    task automatic send_request(mcpl_pkg::request_t r, bit typed,
                                mcpl_pkg::result_t typed_res);
        int gap;
        gap = rand_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(typed ? typed_res : predict_limit(cfg_shadow, r));
        sent_count++;
    endtask

    // wait for the pipeline to empty
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write enable is dropped by the caller after the last write
    task automatic write_cfg(mcpl_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            mcpl_pkg::CFG_WARN_BUFFER:  cfg_shadow.warn_buffer          = val[9:0];
            mcpl_pkg::CFG_MIN_BUFFER:   cfg_shadow.min_buffer           = val[9:0];
            mcpl_pkg::CFG_BUFFER_LIMIT: cfg_shadow.buffer_current_limit = val;
            mcpl_pkg::CFG_POWER_LIMIT:  cfg_shadow.extra_current_limit  = val;
        endcase
    endtask

    task automatic set_phase_cfg(int ph);
        case (ph)
            1:
            begin
                write_cfg(mcpl_pkg::CFG_WARN_BUFFER, 16'd1023);
                write_cfg(mcpl_pkg::CFG_MIN_BUFFER, 16'd0);
                write_cfg(mcpl_pkg::CFG_BUFFER_LIMIT, 16'd65535);
                write_cfg(mcpl_pkg::CFG_POWER_LIMIT, 16'd65535);
            end
            2:
            begin
                // min above warn drives the limit into saturation
                write_cfg(mcpl_pkg::CFG_WARN_BUFFER, 16'd1);
                write_cfg(mcpl_pkg::CFG_MIN_BUFFER, 16'hFFFF);
                write_cfg(mcpl_pkg::CFG_BUFFER_LIMIT, 16'd65535);
                write_cfg(mcpl_pkg::CFG_POWER_LIMIT, 16'd0);
            end
            3:
            begin
                // zero warn level through register masking
                write_cfg(mcpl_pkg::CFG_WARN_BUFFER, 16'hFC00);
                write_cfg(mcpl_pkg::CFG_MIN_BUFFER, 16'd7);
                write_cfg(mcpl_pkg::CFG_BUFFER_LIMIT, 16'd0);
                write_cfg(mcpl_pkg::CFG_POWER_LIMIT, 16'd40000);
            end
            default:
            begin
                write_cfg(mcpl_pkg::CFG_WARN_BUFFER, 16'($urandom_range(1, 1023)));
                write_cfg(mcpl_pkg::CFG_MIN_BUFFER, 16'($urandom_range(0, 1023)));
                write_cfg(mcpl_pkg::CFG_BUFFER_LIMIT, 16'($urandom_range(0, 65535)));
                write_cfg(mcpl_pkg::CFG_POWER_LIMIT, 16'($urandom_range(0, 65535)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_count++;
            if (result.was_limited)
                limited_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                err_count++;
            end
            else
            begin
                mcpl_pkg::result_t exp_res;
                exp_res = pending_results.pop_front();
                if (result.scaled_a !== exp_res.scaled_a)
                    $display("%0t: scaled_a exp %0d got %0d", $time, exp_res.scaled_a,
                             result.scaled_a);
                if (result.scaled_b !== exp_res.scaled_b)
                    $display("%0t: scaled_b exp %0d got %0d", $time, exp_res.scaled_b,
                             result.scaled_b);
                if (result.scaled_c !== exp_res.scaled_c)
                    $display("%0t: scaled_c exp %0d got %0d", $time, exp_res.scaled_c,
                             result.scaled_c);
                if (result.scaled_d !== exp_res.scaled_d)
                    $display("%0t: scaled_d exp %0d got %0d", $time, exp_res.scaled_d,
                             result.scaled_d);
                if (result.total_limit !== exp_res.total_limit)
                    $display("%0t: total_limit exp %0d got %0d", $time, exp_res.total_limit,
                             result.total_limit);
                if (result.was_limited !== exp_res.was_limited)
                    $display("%0t: was_limited exp %0d got %0d", $time, exp_res.was_limited,
                             result.was_limited);
                if (result !== exp_res)
                    err_count++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        mcpl_pkg::result_t none;
        none = '0;
        err_count = 0;
        sent_count = 0;
        seen_count = 0;
        limited_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_shadow.warn_buffer          = mcpl_pkg::WARN_BUFFER_RST;
        cfg_shadow.min_buffer           = mcpl_pkg::MIN_BUFFER_RST;
        cfg_shadow.buffer_current_limit = mcpl_pkg::BUFFER_CUR_RST;
        cfg_shadow.extra_current_limit  = mcpl_pkg::POWER_CUR_RST;

        // directed rows at reset settings
        dir_table[0]  = '{mk_req(0, 1000, 100, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 36000, 0)};
        dir_table[1]  = '{mk_req(0, 0, 100, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 800, 0)};
        dir_table[2]  = '{mk_req(65535, 500, 0, 1000, -1000, 1000, -1000), 1,
                          mk_res(1000, -1000, 1000, -1000, 16000, 0)};
        dir_table[3]  = '{mk_req(0, 0, 100, 32767, 32767, 32767, 32767), 1,
                          mk_res(200, 200, 200, 200, 800, 1)};
        dir_table[4]  = '{mk_req(0, 0, 0, -32768, -32768, -32768, -32768), 0, none};
        dir_table[5]  = '{mk_req(0, 65535, 0, -32768, 32767, -1, 1), 0, none};
        dir_table[6]  = '{mk_req(7500, 100, 100, 20000, -20000, 5, -5), 0, none};
        dir_table[7]  = '{mk_req(5000, 200, 100, 9000, 9000, 9000, 9000), 0, none};
        dir_table[8]  = '{mk_req(5001, 200, 100, 9000, 9000, 9000, 9001), 0, none};
        dir_table[9]  = '{mk_req(9999, 99, 100, 4000, -4000, 4000, -4000), 0, none};
        dir_table[10] = '{mk_req(10000, 150, 100, 16000, 1, 0, 0), 0, none};
        dir_table[11] = '{mk_req(65535, 65535, 65535, 32767, -32768, 32767, -32768), 0, none};
        dir_table[12] = '{mk_req(0, 4, 655, 100, 200, 300, 400), 0, none};
        dir_table[13] = '{mk_req(21845, 43690, 43690, 21845, -21846, 43690, -1), 0, none};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_request(dir_table[i].req, dir_table[i].has_exp, dir_table[i].exp);
        drain();

        // random phases, register settings change between them
        for (int ph = 1; ph <= N_PHASES; ph++)
        begin
            set_phase_cfg(ph);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (n % 64 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_request(rand_request(), 0, none);
            end
            drain();
        end

        $display("covered %0d requests over %0d register settings", sent_count, N_PHASES + 1);
        $display("%0d results checked, %0d of them scaled down", seen_count, limited_count);
        if (err_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* motor_current_power_limiter_top.f */
+incdir+hw/rtl
hw/rtl/mcpl_pkg.sv
hw/rtl/mcpl_div.sv
hw/rtl/mcpl_limit.sv
hw/rtl/mcpl_scale.sv
hw/rtl/motor_current_power_limiter_top.sv
test/tb_motor_current_power_limiter_top.sv
